/* src/lmfc_pkg.sv */
// ----------------------------------------------------------------------------
// lmfc_pkg
// Shared types, codes and constants of the letter multiset fit check block.
// ----------------------------------------------------------------------------
package lmfc_pkg;

   localparam int MAX_SET_LETTERS_DEF = 63;
   localparam int CHAR_W              = 8;
   localparam int EPOCH_W             = 8;
   localparam int LEFT_W              = 6;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_WORD   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [CHAR_W-1:0]  WILD_CHAR   = 8'h5F;
   localparam logic [CHAR_W-1:0]  SPACE_CHAR  = 8'h20;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 8'd0;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;
   localparam logic [CHAR_W-1:0]  ADDR_LAST   = 8'hFF;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } req_type;

   typedef struct packed {
      logic              fits;
      logic [LEFT_W-1:0] letters_left;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [CHAR_W-1:0] wr_addr;
      logic              rd_en;
      logic [CHAR_W-1:0] rd_addr_a;
      logic [CHAR_W-1:0] rd_addr_b;
   } mem_ctl_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Epoch zero marks an invalid entry, so the live epoch skips it.
   function automatic logic [EPOCH_W-1:0] next_epoch(input logic [EPOCH_W-1:0] ep);
      logic [EPOCH_W-1:0] nxt;
      nxt = (ep == EPOCH_LAST) ? EPOCH_FIRST : ep + EPOCH_W'(1);
      return nxt;
   endfunction

endpackage

/* src/lmfc_tag_mem.sv */
// ----------------------------------------------------------------------------
// lmfc_tag_mem
// Per-character memory of tagged counts, one write port and two registered
// read ports.
// ----------------------------------------------------------------------------
module lmfc_tag_mem #(
   parameter int DATA_W = 14
) (
   input  logic                 clock,
   input  lmfc_pkg::mem_ctl_type ctl,
   input  logic [DATA_W-1:0]    wr_data,
   output logic [DATA_W-1:0]    rd_data_a,
   output logic [DATA_W-1:0]    rd_data_b
);

   localparam int DEPTH = 1 << lmfc_pkg::CHAR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_a_ff <= mem[ctl.rd_addr_a];
         rd_b_ff <= mem[ctl.rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* src/lmfc_ctrl.sv */
// ----------------------------------------------------------------------------
// lmfc_ctrl
// Sequencer: reads the set and usage counts, updates them, tracks the word
// and set epochs, runs the clearing sweep and builds the result item.
// ----------------------------------------------------------------------------
module lmfc_ctrl #(
   parameter int MAX_SET_LETTERS = lmfc_pkg::MAX_SET_LETTERS_DEF,
   parameter int CNT_W           = $clog2(MAX_SET_LETTERS + 1),
   parameter int DATA_W          = lmfc_pkg::EPOCH_W + CNT_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lmfc_pkg::req_type     req_item,
   output logic                  rsp_valid,
   output lmfc_pkg::rsp_type     rsp_item,
   output lmfc_pkg::mem_ctl_type set_ctl,
   output logic [DATA_W-1:0]     set_wdata,
   input  logic [DATA_W-1:0]     set_rdata_a,
   input  logic [DATA_W-1:0]     set_rdata_b,
   output lmfc_pkg::mem_ctl_type use_ctl,
   output logic [DATA_W-1:0]     use_wdata,
   input  logic [DATA_W-1:0]     use_rdata_a,
   input  logic [DATA_W-1:0]     use_rdata_b
);

   localparam int EW     = lmfc_pkg::EPOCH_W;
   localparam int AW     = lmfc_pkg::CHAR_W;
   localparam int LW     = (CNT_W > lmfc_pkg::LEFT_W) ? CNT_W : lmfc_pkg::LEFT_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SET_LETTERS);

   lmfc_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       sweep_addr_ff, sweep_addr_in;
   logic                sweep_set_ff, sweep_set_in;
   logic                sweep_use_ff, sweep_use_in;
   logic [EW-1:0]       set_ep_ff, set_ep_in;
   logic [EW-1:0]       use_ep_ff, use_ep_in;
   logic [CNT_W-1:0]    set_len_ff, set_len_in;
   logic [CNT_W-1:0]    used_cnt_ff, used_cnt_in;
   logic                failed_ff, failed_in;
   lmfc_pkg::req_type   cur_ff, cur_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lmfc_pkg::rsp_type   rsp_ff, rsp_in;

   logic [CNT_W-1:0] set_cnt_ch, set_cnt_wild, use_cnt_ch, use_cnt_wild;
   logic             restart;
   logic [LW-1:0]    left_ext;

   always_comb begin
      set_cnt_ch   = (set_rdata_a[DATA_W-1 -: EW] == set_ep_ff) ?
                     set_rdata_a[CNT_W-1:0] : '0;
      set_cnt_wild = (set_rdata_b[DATA_W-1 -: EW] == set_ep_ff) ?
                     set_rdata_b[CNT_W-1:0] : '0;
      use_cnt_ch   = (use_rdata_a[DATA_W-1 -: EW] == use_ep_ff) ?
                     use_rdata_a[CNT_W-1:0] : '0;
      use_cnt_wild = (use_rdata_b[DATA_W-1 -: EW] == use_ep_ff) ?
                     use_rdata_b[CNT_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lmfc_pkg::ST_SWEEP;
         sweep_addr_ff <= '0;
         sweep_set_ff  <= 1'b1;
         sweep_use_ff  <= 1'b1;
         set_ep_ff     <= lmfc_pkg::EPOCH_FIRST;
         use_ep_ff     <= lmfc_pkg::EPOCH_FIRST;
         set_len_ff    <= '0;
         used_cnt_ff   <= '0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_set_ff  <= sweep_set_in;
         sweep_use_ff  <= sweep_use_in;
         set_ep_ff     <= set_ep_in;
         use_ep_ff     <= use_ep_in;
         set_len_ff    <= set_len_in;
         used_cnt_ff   <= used_cnt_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_set_in  = sweep_set_ff;
      sweep_use_in  = sweep_use_ff;
      set_ep_in     = set_ep_ff;
      use_ep_in     = use_ep_ff;
      set_len_in    = set_len_ff;
      used_cnt_in   = used_cnt_ff;
      failed_in     = failed_ff;
      cur_in        = cur_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      restart       = 1'b0;
      left_ext      = '0;

      set_ctl           = '0;
      set_ctl.rd_addr_b = lmfc_pkg::WILD_CHAR;
      use_ctl           = '0;
      use_ctl.rd_addr_b = lmfc_pkg::WILD_CHAR;
      set_wdata         = '0;
      use_wdata         = '0;

      case (state_ff)
         lmfc_pkg::ST_SWEEP: begin
            set_ctl.wr_en   = sweep_set_ff;
            set_ctl.wr_addr = sweep_addr_ff;
            use_ctl.wr_en   = sweep_use_ff;
            use_ctl.wr_addr = sweep_addr_ff;
            set_wdata       = {lmfc_pkg::EPOCH_NONE, CNT_W'(0)};
            use_wdata       = {lmfc_pkg::EPOCH_NONE, CNT_W'(0)};
            sweep_addr_in   = sweep_addr_ff + AW'(1);
            if (sweep_addr_ff == lmfc_pkg::ADDR_LAST) begin
               sweep_set_in = 1'b0;
               sweep_use_in = 1'b0;
               state_in     = lmfc_pkg::ST_IDLE;
            end
         end
         lmfc_pkg::ST_IDLE: begin
            set_ctl.rd_en     = start;
            set_ctl.rd_addr_a = req_item.char_code;
            use_ctl.rd_en     = start;
            use_ctl.rd_addr_a = req_item.char_code;
            if (start) begin
               cur_in   = req_item;
               state_in = lmfc_pkg::ST_EXEC;
            end
         end
         lmfc_pkg::ST_EXEC: begin
            case (cur_ff.opcode)
               lmfc_pkg::OP_APPEND: begin
                  if (set_len_ff < MAX_CNT) begin
                     set_ctl.wr_en   = 1'b1;
                     set_ctl.wr_addr = cur_ff.char_code;
                     set_wdata       = {set_ep_ff, set_cnt_ch + CNT_W'(1)};
                     set_len_in      = set_len_ff + CNT_W'(1);
                  end
                  restart = 1'b1;
               end
               lmfc_pkg::OP_CLEAR: begin
                  set_len_in = '0;
                  set_ep_in  = lmfc_pkg::next_epoch(set_ep_ff);
                  if (set_ep_ff == lmfc_pkg::EPOCH_LAST) begin
                     sweep_set_in = 1'b1;
                  end
                  restart = 1'b1;
               end
               lmfc_pkg::OP_WORD: begin
                  if (cur_ff.char_code != lmfc_pkg::SPACE_CHAR && !failed_ff) begin
                     if (set_cnt_ch != use_cnt_ch) begin
                        use_ctl.wr_en   = 1'b1;
                        use_ctl.wr_addr = cur_ff.char_code;
                        use_wdata       = {use_ep_ff, use_cnt_ch + CNT_W'(1)};
                        used_cnt_in     = used_cnt_ff + CNT_W'(1);
                     end else if (set_cnt_wild != use_cnt_wild) begin
                        use_ctl.wr_en   = 1'b1;
                        use_ctl.wr_addr = lmfc_pkg::WILD_CHAR;
                        use_wdata       = {use_ep_ff, use_cnt_wild + CNT_W'(1)};
                        used_cnt_in     = used_cnt_ff + CNT_W'(1);
                     end else begin
                        failed_in = 1'b1;
                     end
                  end
                  if (cur_ff.last_char) begin
                     left_ext          = LW'(set_len_ff - used_cnt_in);
                     rsp_valid_in      = 1'b1;
                     rsp_in.fits       = !failed_in;
                     rsp_in.letters_left = failed_in ? '0 : left_ext[lmfc_pkg::LEFT_W-1:0];
                     restart           = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (restart) begin
               used_cnt_in = '0;
               failed_in   = 1'b0;
               use_ep_in   = lmfc_pkg::next_epoch(use_ep_ff);
               if (use_ep_ff == lmfc_pkg::EPOCH_LAST) begin
                  sweep_use_in = 1'b1;
               end
            end
            state_in = (sweep_set_in || sweep_use_in) ? lmfc_pkg::ST_SWEEP :
                       lmfc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lmfc_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != lmfc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == lmfc_pkg::ST_EXEC))
      else $error("Result item without a preceding execute cycle.");

   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      set_ep_ff != lmfc_pkg::EPOCH_NONE && use_ep_ff != lmfc_pkg::EPOCH_NONE)
      else $error("Live epoch took the invalid value.");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_cnt_ff <= set_len_ff)
      else $error("Word used more letters than the set holds.");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.fits |-> rsp_ff.letters_left == '0)
      else $error("Failed word reported leftover letters.");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      start && state_ff == lmfc_pkg::ST_IDLE |=> state_ff == lmfc_pkg::ST_EXEC)
      else $error("Accepted item did not enter the execute cycle.");

endmodule

/* src/letter_multiset_fit_check_core.sv */
// ----------------------------------------------------------------------------
// letter_multiset_fit_check_core
// Checks whether words can be built from a loaded letter set with wildcards.
// ----------------------------------------------------------------------------
// An item is taken from req_item when start is high and busy is low. Opcode
// append adds one letter to the set unless it is full, clear empties it, and
// word feeds one character of the current word; spaces are skipped and '_' in
// the set is a wildcard. The word item marked last_char returns one result
// item on rsp_item, flagged by rsp_valid for exactly one cycle and registered
// after the execute state; the receiver cannot hold it off. Each item has an
// accept cycle that reads the set and usage memories at the character and
// the wildcard, then an execute state, with busy high, that may update one
// of them. Usage and set counts are invalidated per word and per clear by
// epoch tags, so word restart is free. After reset, and after every 255 word
// restarts or 255 clears, all 256 entries are cleared with busy high.
// ----------------------------------------------------------------------------
module letter_multiset_fit_check_core #(
   parameter int MAX_SET_LETTERS = lmfc_pkg::MAX_SET_LETTERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lmfc_pkg::req_type req_item,
   output logic              rsp_valid,
   output lmfc_pkg::rsp_type rsp_item
);

   localparam int CNT_W  = $clog2(MAX_SET_LETTERS + 1);
   localparam int DATA_W = lmfc_pkg::EPOCH_W + CNT_W;

   lmfc_pkg::mem_ctl_type set_ctl, use_ctl;
   logic [DATA_W-1:0]     set_wdata, set_rdata_a, set_rdata_b;
   logic [DATA_W-1:0]     use_wdata, use_rdata_a, use_rdata_b;

   lmfc_ctrl #(
      .MAX_SET_LETTERS(MAX_SET_LETTERS),
      .CNT_W(CNT_W),
      .DATA_W(DATA_W)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .set_ctl(set_ctl),
      .set_wdata(set_wdata),
      .set_rdata_a(set_rdata_a),
      .set_rdata_b(set_rdata_b),
      .use_ctl(use_ctl),
      .use_wdata(use_wdata),
      .use_rdata_a(use_rdata_a),
      .use_rdata_b(use_rdata_b)
   );

   lmfc_tag_mem #(.DATA_W(DATA_W)) u_set_mem (
      .clock(clock),
      .ctl(set_ctl),
      .wr_data(set_wdata),
      .rd_data_a(set_rdata_a),
      .rd_data_b(set_rdata_b)
   );

   lmfc_tag_mem #(.DATA_W(DATA_W)) u_use_mem (
      .clock(clock),
      .ctl(use_ctl),
      .wr_data(use_wdata),
      .rd_data_a(use_rdata_a),
      .rd_data_b(use_rdata_b)
   );

endmodule

/* sim/lmfc_fit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lmfc_fit_checker
// Watches the item and result channels of the letter multiset fit check
// block, keeps its own copy of the letter set and the word in progress, and
// compares every result item with the oldest predicted one.
// ----------------------------------------------------------------------------
module lmfc_fit_checker #(
   parameter int MAX_SET_LETTERS = lmfc_pkg::MAX_SET_LETTERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  lmfc_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  lmfc_pkg::rsp_type rsp_item,
   output int                error_count,
   output int                pending_count
);
   import lmfc_pkg::*;

   logic [LEFT_W-1:0] set_tally [256];
   logic [LEFT_W-1:0] free_tally [256];
   logic [LEFT_W-1:0] set_size;
   logic [LEFT_W-1:0] taken;
   logic              word_lost;
   rsp_type           expected_fits [$];
   int                mismatches = 0;

   task automatic restart_word();
      for (int i = 0; i < 256; i++) begin
         free_tally[i] = set_tally[i];
      end
      taken     = '0;
      word_lost = 1'b0;
   endtask

   task automatic empty_set();
      for (int i = 0; i < 256; i++) begin
         set_tally[i] = '0;
      end
      set_size = '0;
      restart_word();
   endtask

   task automatic predict_fit(input req_type item);
      rsp_type res;
      case (item.opcode)
         OP_APPEND: begin
            if (set_size < MAX_SET_LETTERS) begin
               set_tally[item.char_code] = set_tally[item.char_code] + 1'b1;
               set_size = set_size + 1'b1;
            end
            restart_word();
         end
         OP_CLEAR: begin
            empty_set();
         end
         OP_WORD: begin
            if (item.char_code != SPACE_CHAR && !word_lost) begin
               if (free_tally[item.char_code] != '0) begin
                  free_tally[item.char_code] = free_tally[item.char_code] - 1'b1;
                  taken = taken + 1'b1;
               end else if (free_tally[WILD_CHAR] != '0) begin
                  free_tally[WILD_CHAR] = free_tally[WILD_CHAR] - 1'b1;
                  taken = taken + 1'b1;
               end else begin
                  word_lost = 1'b1;
               end
            end
            if (item.last_char) begin
               res.fits         = !word_lost;
               res.letters_left = word_lost ? '0 : LEFT_W'(set_size - taken);
               expected_fits.push_back(res);
               restart_word();
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_fits.size() == 0) begin
         $display("%0t: unexpected result fits=%0b letters_left=%0d, none expected",
                  $time, got.fits, got.letters_left);
         mismatches++;
      end else begin
         want = expected_fits.pop_front();
         if (got.fits !== want.fits) begin
            $display("%0t: fits mismatch: expected %0b, actual %0b",
                     $time, want.fits, got.fits);
            mismatches++;
         end
         if (got.letters_left !== want.letters_left) begin
            $display("%0t: letters_left mismatch: expected %0d, actual %0d",
                     $time, want.letters_left, got.letters_left);
            mismatches++;
         end
      end
   endtask

   // A result always belongs to an earlier item, so it is checked before the
   // item accepted at the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         empty_set();
         expected_fits.delete();
      end else begin
         if (rsp_valid) begin
            check_result(rsp_item);
         end
         if (start && !busy) begin
            predict_fit(req_item);
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_fits.size();
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the letter multiset fit check block.
// ----------------------------------------------------------------------------
// A short directed part covers empty and failing words, wildcards, spaces,
// the extreme character codes, set changes in the middle of a word and the
// unused opcode. Random letter sets and words follow, with appends and
// clears thrown into words, under three phases of sender idling. A checker
// beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
   import lmfc_pkg::*;

   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam int         ITEM_TARGET    = 900;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         TAIL_CYCLES    = 8;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      error_count;
   int      pending_count;
   int      items_sent   = 0;
   int      stall_cycles = 0;

   always #5 clock = ~clock;

   letter_multiset_fit_check_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   lmfc_fit_checker fit_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Mostly a small alphabet so that words often fit, with wildcards, spaces
   // and arbitrary bytes mixed in.
   function automatic logic [7:0] pick_char();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) begin
         return 8'h61 + 8'($urandom_range(4));
      end else if (roll < 70) begin
         return WILD_CHAR;
      end else if (roll < 80) begin
         return SPACE_CHAR;
      end
      return 8'($urandom_range(255));
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send(input logic [1:0] op, input logic [7:0] code, input logic last);
      req_type item;
      int      gap_pct;
      item.opcode    = op;
      item.char_code = code;
      item.last_char = last;
      gap_pct = (items_sent < 300) ? 34 : (items_sent < 600) ? 72 : 0;
      while ($urandom_range(99) < gap_pct) begin
         start    <= 1'b0;
         req_item <= req_type'($urandom);
         @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      @(negedge clock);
      if (op != OP_UNUSED) begin
         items_sent++;
      end
   endtask

   task automatic send_word(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send(OP_WORD, text[i], i == text.len() - 1);
      end
   endtask

   initial begin
      int choice;
      int count;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(" ");
      send_word("a");
      send(OP_APPEND, "a", 1'b1);
      send(OP_APPEND, "b", 1'b0);
      send(OP_APPEND, WILD_CHAR, 1'b0);
      send(OP_APPEND, 8'h00, 1'b0);
      send(OP_APPEND, 8'hFF, 1'b0);
      send_word("ab");
      send_word("_x");
      send_word("aa");
      send_word("xqa");
      send(OP_WORD, 8'h00, 1'b0);
      send(OP_WORD, 8'hFF, 1'b1);
      send(OP_WORD, "a", 1'b0);
      send(OP_APPEND, "c", 1'b0);
      send(OP_WORD, "c", 1'b1);
      send(OP_UNUSED, 8'($urandom_range(255)), 1'b1);
      send(OP_CLEAR, "z", 1'b1);
      send_word("  ");

      while (items_sent < ITEM_TARGET) begin
         choice = $urandom_range(99);
         if (choice < 8) begin
            send(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (choice < 14) begin
            send(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (choice < 26) begin
            if ($urandom_range(1) == 1) begin
               send(OP_CLEAR, 8'($urandom_range(255)), 1'b0);
            end
            count = ($urandom_range(7) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 10);
            repeat (count) begin
               send(OP_APPEND, pick_char(), 1'($urandom_range(1)));
            end
         end else begin
            count = $urandom_range(0, 7);
            for (int k = 0; k < count; k++) begin
               send(OP_WORD, pick_char(), 1'b0);
               if ($urandom_range(49) == 0) begin
                  send(($urandom_range(1) == 1) ? OP_APPEND : OP_CLEAR, pick_char(), 1'b0);
               end
            end
            send(OP_WORD, pick_char(), 1'b1);
         end
      end
      start <= 1'b0;

      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/lmfc_pkg.sv
src/lmfc_tag_mem.sv
src/lmfc_ctrl.sv
src/letter_multiset_fit_check_core.sv
sim/lmfc_fit_checker.sv
sim/testbench.sv
